// ===== rtl/ps2mpt_pkg.sv =====
// Shared constants and types for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

    localparam int LIMIT_W   = 13;
    localparam int POS_W_DEF = 12;
    localparam int BTN_W     = 3;
    localparam int WHEEL_W   = 4;
    localparam int MOVE_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 13'd800;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 13'd480;

    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_B0   = 2'd0;
    localparam t_slot SLOT_B1   = 2'd1;
    localparam t_slot SLOT_B2   = 2'd2;
    localparam t_slot SLOT_LAST = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } t_cfg_idx;

endpackage

// ===== rtl/ps2mpt_if.sv =====
// Valid/ready channel interfaces for mouse bytes and packet results.
interface ps2mpt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ps2mpt_pkt_if #(
    parameter int POS_WIDTH = 12
);
    logic                  valid;
    logic                  ready;
    logic [POS_WIDTH-1:0]  cursor_x;
    logic [POS_WIDTH-1:0]  cursor_y;
    logic [2:0]            buttons_now;
    logic [2:0]            buttons_pressed;
    logic [2:0]            buttons_released;
    logic                  left_held;
    logic signed [3:0]     wheel_delta;

    modport source (
        output valid, output cursor_x, output cursor_y, output buttons_now,
        output buttons_pressed, output buttons_released, output left_held,
        output wheel_delta, input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input buttons_now,
        input buttons_pressed, input buttons_released, input left_held,
        input wheel_delta, output ready
    );
endinterface

// ===== rtl/ps2mpt_axis.sv =====
// One cursor axis: add signed movement and clamp to 0..limit-1.
module ps2mpt_axis
    import ps2mpt_pkg::*;
#(
    parameter int POS_WIDTH = POS_W_DEF
) (
    input  logic [POS_WIDTH-1:0]     i_pos,
    input  logic signed [MOVE_W-1:0] i_rel,
    input  logic [LIMIT_W-1:0]       i_limit,
    output logic [POS_WIDTH-1:0]     o_pos
);

    localparam int SW = POS_WIDTH + 2;
    localparam logic [31:0] CAP = 32'(1) << POS_WIDTH;

    logic [31:0]          lim32;
    logic [POS_WIDTH-1:0] ub;
    logic signed [SW-1:0] sum;

    assign lim32 = 32'(i_limit);

    always_comb begin
        if (i_limit == '0) begin
            ub = '0;
        end else if (lim32 > CAP) begin
            ub = '1;
        end else begin
            ub = POS_WIDTH'(lim32 - 32'd1);
        end
    end

    assign sum = $signed({2'b00, i_pos}) + SW'(i_rel);

    always_comb begin
        if (i_rel == '0) begin
            o_pos = i_pos;
        end else if (sum[SW-1]) begin
            o_pos = '0;
        end else if (sum[SW-2:0] > {1'b0, ub}) begin
            o_pos = ub;
        end else begin
            o_pos = sum[POS_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// PS/2 wheel-mouse packet tracker top level.
// The result of a packet is registered and valid in the cycle after its fourth byte is taken.
// Throughput: one byte per cycle; a result that waits on the output stalls every byte.
// The single output register sets the rate: it refills in the cycle it is drained.
// Reset (synchronous, active low): limits 800/480, cursor at half of them, framing at byte 0.
module ps2_mouse_packet_tracker
    import ps2mpt_pkg::*;
#(
    parameter int POS_WIDTH = POS_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    ps2mpt_byte_if.sink          i_byte_if,
    ps2mpt_pkt_if.source         o_pkt_if
);

    localparam logic [POS_WIDTH-1:0] X_POS_RST = POS_WIDTH'(X_LIMIT_RST / 2);
    localparam logic [POS_WIDTH-1:0] Y_POS_RST = POS_WIDTH'(Y_LIMIT_RST / 2);

    logic [LIMIT_W-1:0]   r_x_limit, r_y_limit;
    t_slot                r_slot;
    logic [7:0]           r_b0, r_b1, r_b2;
    logic [BTN_W-1:0]     r_last_btn;
    logic [POS_WIDTH-1:0] r_pos_x, r_pos_y;
    logic                 r_left;
    logic                 r_ovalid;

    logic [POS_WIDTH-1:0] r_cx, r_cy;
    logic [BTN_W-1:0]     r_now, r_down, r_up;
    logic                 r_lheld;
    logic [WHEEL_W-1:0]   r_wheel;

    logic                 accept, last_byte;
    logic [BTN_W-1:0]     btn, down, up;
    logic signed [MOVE_W-1:0] relx, rely;
    logic [POS_WIDTH-1:0] n_pos_x, n_pos_y;
    logic                 n_left;

    assign i_byte_if.ready = !r_ovalid || o_pkt_if.ready;
    assign accept    = i_byte_if.valid && i_byte_if.ready;
    assign last_byte = (r_slot == SLOT_LAST);

    assign btn  = r_b0[BTN_W-1:0];
    assign down = (btn ^ r_last_btn) & btn;
    assign up   = (btn ^ r_last_btn) & r_last_btn;
    assign relx = $signed({r_b0[X_SIGN_BIT], r_b0[X_SIGN_BIT], r_b1});
    assign rely = -$signed({r_b0[Y_SIGN_BIT], r_b0[Y_SIGN_BIT], r_b2});

    always_comb begin
        n_left = r_left;
        if (down[0]) begin
            n_left = 1'b1;
        end
        if (up[0]) begin
            n_left = 1'b0;
        end
    end

    ps2mpt_axis #(.POS_WIDTH(POS_WIDTH)) u_axis_x (
        .i_pos   (r_pos_x),
        .i_rel   (relx),
        .i_limit (r_x_limit),
        .o_pos   (n_pos_x)
    );

    ps2mpt_axis #(.POS_WIDTH(POS_WIDTH)) u_axis_y (
        .i_pos   (r_pos_y),
        .i_rel   (rely),
        .i_limit (r_y_limit),
        .o_pos   (n_pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= X_LIMIT_RST;
            r_y_limit <= Y_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_LIMIT: r_x_limit <= i_cfg_data;
                CFG_Y_LIMIT: r_y_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= SLOT_B0;
            r_b0       <= '0;
            r_b1       <= '0;
            r_b2       <= '0;
            r_last_btn <= '0;
            r_pos_x    <= X_POS_RST;
            r_pos_y    <= Y_POS_RST;
            r_left     <= 1'b0;
        end else if (accept) begin
            r_slot <= r_slot + 2'd1;
            case (r_slot)
                SLOT_B0: r_b0 <= i_byte_if.data_byte;
                SLOT_B1: r_b1 <= i_byte_if.data_byte;
                SLOT_B2: r_b2 <= i_byte_if.data_byte;
                SLOT_LAST: begin
                    r_last_btn <= btn;
                    r_pos_x    <= n_pos_x;
                    r_pos_y    <= n_pos_y;
                    r_left     <= n_left;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept && last_byte) begin
            r_ovalid <= 1'b1;
        end else if (o_pkt_if.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last_byte) begin
            r_cx    <= n_pos_x;
            r_cy    <= n_pos_y;
            r_now   <= btn;
            r_down  <= down;
            r_up    <= up;
            r_lheld <= n_left;
            r_wheel <= i_byte_if.data_byte[WHEEL_W-1:0];
        end
    end

    assign o_pkt_if.valid            = r_ovalid;
    assign o_pkt_if.cursor_x         = r_cx;
    assign o_pkt_if.cursor_y         = r_cy;
    assign o_pkt_if.buttons_now      = r_now;
    assign o_pkt_if.buttons_pressed  = r_down;
    assign o_pkt_if.buttons_released = r_up;
    assign o_pkt_if.left_held        = r_lheld;
    assign o_pkt_if.wheel_delta      = $signed(r_wheel);

endmodule

// ===== rtl/ps2mpt_checker.sv =====
// Port-level assertions for the packet tracker, bound to the top level.
module ps2mpt_checker
    import ps2mpt_pkg::*;
#(
    parameter int POS_WIDTH = POS_W_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [POS_WIDTH-1:0] i_cx,
    input logic [POS_WIDTH-1:0] i_cy,
    input logic [BTN_W-1:0]     i_now,
    input logic [BTN_W-1:0]     i_down,
    input logic [BTN_W-1:0]     i_up,
    input logic                 i_left
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_cx) && $stable(i_cy))
        else $error("stalled result changed");

    a_edges_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_down & ~i_now) == '0) && ((i_up & i_now) == '0))
        else $error("press/release edges disagree with buttons");

    a_left_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_left == i_now[0]))
        else $error("left held state disagrees with left button");

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker #(.POS_WIDTH(POS_WIDTH)) u_ps2mpt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_pkt_if.valid),
    .i_ready (o_pkt_if.ready),
    .i_cx    (o_pkt_if.cursor_x),
    .i_cy    (o_pkt_if.cursor_y),
    .i_now   (o_pkt_if.buttons_now),
    .i_down  (o_pkt_if.buttons_pressed),
    .i_up    (o_pkt_if.buttons_released),
    .i_left  (o_pkt_if.left_held)
);
